@@ hw/rtl/itms_pkg.sv @@
// Shared types, constants and sequencer states for the intercept time selector.
`default_nettype none
package itms_pkg;

    localparam int NUM_ROBOTS = 16;
    localparam int IDX_W      = 4;
    localparam logic [IDX_W-1:0] ROBOT_LIMIT =
        IDX_W'((NUM_ROBOTS > 16 ? 16 : NUM_ROBOTS) - 1);

    localparam logic [31:0] TIME_SAT     = 32'hFFFF_FFFD;
    localparam logic [31:0] TIME_UNREACH = 32'hFFFF_FFFE;
    localparam logic [31:0] TIME_NONE    = 32'hFFFF_FFFF;

    localparam logic [31:0] TOP_SPEED_RST = 32'd131072;
    localparam logic        REG_TOP_SPEED = 1'b0;

    typedef struct packed {
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic               robot_team;
        logic signed [31:0] ball_x;
        logic signed [31:0] ball_y;
        logic signed [31:0] ball_vx;
        logic signed [31:0] ball_vy;
        logic               last_robot;
    } in_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] best_robot;
        logic [31:0]      win_time;
        logic [IDX_W-1:0] team0_robot;
        logic [31:0]      team0_time;
        logic [IDX_W-1:0] team1_robot;
        logic [31:0]      team1_time;
    } out_beat_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CALC,
        T_UPD
    } top_state_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_PREP,
        C_MUL,
        C_COEF,
        C_RAD,
        C_SQRT,
        C_NUM,
        C_DCHK,
        C_DIV,
        C_DONE
    } calc_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/itms_calc.sv @@
// Iterative intercept time unit: shared 33x33 multiplier, square root and divider.
`default_nettype none
module itms_calc
    import itms_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire in_beat_t    item,
    input  wire logic [31:0] top_speed,
    output logic             done,
    output logic [31:0]      time_out
);

    localparam logic [3:0] OP_SS   = 4'd0;
    localparam logic [3:0] OP_VXX  = 4'd1;
    localparam logic [3:0] OP_VYY  = 4'd2;
    localparam logic [3:0] OP_DXX  = 4'd3;
    localparam logic [3:0] OP_DYY  = 4'd4;
    localparam logic [3:0] OP_VDX  = 4'd5;
    localparam logic [3:0] OP_VDY  = 4'd6;
    localparam logic [3:0] OP_BB   = 4'd7;
    localparam logic [3:0] OP_AC   = 4'd8;

    localparam logic [6:0] MUL_LAST  = 7'd4;
    localparam logic [6:0] SQRT_LAST = 7'd65;
    localparam logic [6:0] DIV_LAST  = 7'd33;

    calc_state_t state_reg, state_next;

    logic [32:0]  adx_reg, ady_reg;
    logic [31:0]  avx_reg, avy_reg;
    logic         n1_reg, n2_reg;
    logic [3:0]   sel_reg;
    logic [6:0]   cnt_reg;
    logic [65:0]  prod_reg;
    logic [1:0]   pshift_reg;
    logic [131:0] acc_reg;
    logic [63:0]  s2_reg, v2_reg, m1_reg, m2_reg;
    logic [65:0]  c_reg;
    logic [127:0] bb_reg;
    logic [129:0] ac_reg;
    logic         aneg_reg, bneg_reg;
    logic [63:0]  amag_reg, bmag_reg;
    logic [131:0] x_reg, r_reg, bit_reg;
    logic [33:0]  q_reg;
    logic [31:0]  time_reg;

    logic signed [32:0] dx_c, dy_c;
    logic [65:0]  op_a, op_b;
    logic [32:0]  a_limb, b_limb;
    logic [65:0]  prod_c;
    logic [131:0] term_c, acc_sum;
    logic         zero_c, aneg_c, bneg_c, unreach_c, sat_c;
    logic [63:0]  amag_c, bmag_c;
    logic [131:0] trial_c;
    logic         sq_ge;
    logic [66:0]  num_c;
    logic         dv_ge;
    logic [33:0]  q_fin;

    assign dx_c = 33'(item.robot_x) - 33'(item.ball_x);
    assign dy_c = 33'(item.robot_y) - 33'(item.ball_y);

    always_comb begin
        case (sel_reg)
            OP_SS: begin
                op_a = 66'(top_speed);
                op_b = 66'(top_speed);
            end
            OP_VXX: begin
                op_a = 66'(avx_reg);
                op_b = 66'(avx_reg);
            end
            OP_VYY: begin
                op_a = 66'(avy_reg);
                op_b = 66'(avy_reg);
            end
            OP_DXX: begin
                op_a = 66'(adx_reg);
                op_b = 66'(adx_reg);
            end
            OP_DYY: begin
                op_a = 66'(ady_reg);
                op_b = 66'(ady_reg);
            end
            OP_VDX: begin
                op_a = 66'(avx_reg);
                op_b = 66'(adx_reg);
            end
            OP_VDY: begin
                op_a = 66'(avy_reg);
                op_b = 66'(ady_reg);
            end
            OP_BB: begin
                op_a = 66'(bmag_reg);
                op_b = 66'(bmag_reg);
            end
            OP_AC: begin
                op_a = 66'(amag_reg);
                op_b = c_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign a_limb = cnt_reg[1] ? op_a[65:33] : op_a[32:0];
    assign b_limb = cnt_reg[0] ? op_b[65:33] : op_b[32:0];
    assign prod_c = 66'(a_limb) * 66'(b_limb);

    always_comb begin
        case (pshift_reg)
            2'd0:    term_c = {66'b0, prod_reg};
            2'd1:    term_c = {33'b0, prod_reg, 33'b0};
            2'd2:    term_c = {prod_reg, 66'b0};
            default: term_c = '0;
        endcase
    end
    assign acc_sum = acc_reg + term_c;

    always_comb begin
        zero_c = (s2_reg == v2_reg) || (adx_reg == '0 && ady_reg == '0);
        aneg_c = s2_reg < v2_reg;
        amag_c = aneg_c ? (v2_reg - s2_reg) : (s2_reg - v2_reg);
        if (n1_reg == n2_reg) begin
            bmag_c = m1_reg + m2_reg;
            bneg_c = n1_reg;
        end else if (m1_reg >= m2_reg) begin
            bmag_c = m1_reg - m2_reg;
            bneg_c = n1_reg;
        end else begin
            bmag_c = m2_reg - m1_reg;
            bneg_c = n2_reg;
        end
        if (bmag_c == '0) begin
            bneg_c = 1'b0;
        end
    end

    assign unreach_c = aneg_reg &&
        (bneg_reg || bmag_reg == '0 || 130'(bb_reg) < ac_reg);

    assign trial_c = r_reg | bit_reg;
    assign sq_ge   = x_reg >= trial_c;

    always_comb begin
        if (aneg_reg) begin
            num_c = 67'(bmag_reg) - 67'(r_reg[65:0]);
        end else if (bneg_reg) begin
            num_c = 67'(r_reg[65:0]) + 67'(bmag_reg);
        end else begin
            num_c = 67'(r_reg[65:0]) - 67'(bmag_reg);
        end
    end

    assign sat_c = x_reg >= {34'b0, amag_reg, 34'b0};
    assign dv_ge = x_reg >= r_reg;
    assign q_fin = {q_reg[32:0], dv_ge};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE: if (start) state_next = C_PREP;
            C_PREP: state_next = C_MUL;
            C_MUL: begin
                if (cnt_reg == MUL_LAST && sel_reg == OP_VDY) begin
                    state_next = C_COEF;
                end else if (cnt_reg == MUL_LAST && sel_reg == OP_AC) begin
                    state_next = C_RAD;
                end
            end
            C_COEF: state_next = zero_c ? C_DONE : C_MUL;
            C_RAD:  state_next = unreach_c ? C_DONE : C_SQRT;
            C_SQRT: if (cnt_reg == SQRT_LAST) state_next = C_NUM;
            C_NUM:  state_next = C_DCHK;
            C_DCHK: state_next = sat_c ? C_DONE : C_DIV;
            C_DIV:  if (cnt_reg == DIV_LAST) state_next = C_DONE;
            C_DONE: state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_comb begin
        done     = (state_reg == C_DONE);
        time_out = time_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            C_PREP: begin
                adx_reg <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
                ady_reg <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
                avx_reg <= item.ball_vx[31] ? 32'(-item.ball_vx) : 32'(item.ball_vx);
                avy_reg <= item.ball_vy[31] ? 32'(-item.ball_vy) : 32'(item.ball_vy);
                n1_reg  <= item.ball_vx[31] ^ dx_c[32];
                n2_reg  <= item.ball_vy[31] ^ dy_c[32];
                sel_reg <= OP_SS;
                cnt_reg <= '0;
                acc_reg <= '0;
            end
            C_MUL: begin
                if (!cnt_reg[2]) begin
                    prod_reg   <= prod_c;
                    pshift_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                end
                if (cnt_reg == MUL_LAST) begin
                    case (sel_reg)
                        OP_SS:   s2_reg <= acc_sum[63:0];
                        OP_VYY:  v2_reg <= acc_sum[63:0];
                        OP_DYY:  c_reg  <= acc_sum[65:0];
                        OP_VDX:  m1_reg <= acc_sum[63:0];
                        OP_VDY:  m2_reg <= acc_sum[63:0];
                        OP_BB:   bb_reg <= acc_sum[127:0];
                        OP_AC:   ac_reg <= acc_sum[129:0];
                        default: ;
                    endcase
                    sel_reg <= sel_reg + 4'd1;
                    cnt_reg <= '0;
                    acc_reg <= (sel_reg == OP_VXX || sel_reg == OP_DXX) ? acc_sum : '0;
                end else begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_sum;
                    end
                end
            end
            C_COEF: begin
                aneg_reg <= aneg_c;
                amag_reg <= amag_c;
                bneg_reg <= bneg_c;
                bmag_reg <= bmag_c;
                sel_reg  <= OP_BB;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                time_reg <= '0;
            end
            C_RAD: begin
                x_reg    <= aneg_reg ? 132'(130'(bb_reg) - ac_reg)
                                     : 132'(130'(bb_reg) + ac_reg);
                r_reg    <= '0;
                bit_reg  <= 132'(1) << 130;
                cnt_reg  <= '0;
                time_reg <= TIME_UNREACH;
            end
            C_SQRT: begin
                if (sq_ge) begin
                    x_reg <= x_reg - trial_c;
                    r_reg <= (r_reg >> 1) | bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 7'd1;
            end
            C_NUM: begin
                x_reg <= {49'b0, num_c, 16'b0};
                r_reg <= {35'b0, amag_reg, 33'b0};
            end
            C_DCHK: begin
                q_reg    <= '0;
                cnt_reg  <= '0;
                time_reg <= TIME_SAT;
            end
            C_DIV: begin
                if (dv_ge) begin
                    x_reg <= x_reg - r_reg;
                end
                r_reg   <= r_reg >> 1;
                q_reg   <= q_fin;
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == DIV_LAST) begin
                    time_reg <= (q_fin > 34'(TIME_SAT)) ? TIME_SAT : q_fin[31:0];
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/intercept_time_min_select.sv @@
// Top level: input beat capture, running minima, result register and APB register.
//
// One beat on s_ (valid/ready) carries one robot together with the ball state;
// its index in the frame is its position in the stream. Each robot's earliest
// intercept time is worked out by a sequential unit built around one shared
// 33x33 multiplier, a 66-step square root and a 34-step divider. s_ready is
// high only while the block is idle: each robot runs through the nine
// multiplies, the square root loop and the divide loop before the next one
// can be accepted; robots on the ball or with equal speeds, unreachable ones
// and saturated ones leave the sequence early.
// A beat with last_robot set produces one m_ beat, valid in the same cycle
// that the block is ready again, holding the overall and per-team winners, then the
// frame clears. The result sits in an output register; if the receiver stalls,
// the block still takes the next robots and only waits if a second result is
// due before the first is taken.
// Register top_speed (unsigned Q16.16) sits at APB address 0; write it
// only while idle. Reset (aresetn low, synchronous) clears the frame, drops
// any pending result and sets top_speed to 2.0.
`default_nettype none
module intercept_time_min_select
    import itms_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    top_state_t state_reg, state_next;

    in_beat_t         item_reg;
    logic [31:0]      top_speed_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [31:0]      ovt_reg, t0t_reg, t1t_reg, t_reg;
    logic [IDX_W-1:0] ovi_reg, t0i_reg, t1i_reg;
    logic             m_valid_reg;
    out_beat_t        m_data_reg;

    logic             calc_done;
    logic [31:0]      calc_time;
    logic             s_fire, upd_go, emit;
    logic [31:0]      ovt_n, t0t_n, t1t_n;
    logic [IDX_W-1:0] ovi_n, t0i_n, t1i_n;

    itms_calc u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_fire),
        .item      (item_reg),
        .top_speed (top_speed_reg),
        .done      (calc_done),
        .time_out  (calc_time)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:  if (s_valid) state_next = T_CALC;
            T_CALC:  if (calc_done) state_next = T_UPD;
            T_UPD:   if (upd_go) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == T_IDLE);
        s_fire  = s_valid && s_ready;
        upd_go  = (state_reg == T_UPD) &&
                  !(item_reg.last_robot && m_valid_reg && !m_ready);
        emit    = upd_go && item_reg.last_robot;
    end

    always_comb begin
        ovt_n = ovt_reg;
        ovi_n = ovi_reg;
        t0t_n = t0t_reg;
        t0i_n = t0i_reg;
        t1t_n = t1t_reg;
        t1i_n = t1i_reg;
        if (t_reg < ovt_reg) begin
            ovt_n = t_reg;
            ovi_n = cnt_reg;
        end
        if (!item_reg.robot_team) begin
            if (t_reg < t0t_reg) begin
                t0t_n = t_reg;
                t0i_n = cnt_reg;
            end
        end else begin
            if (t_reg < t1t_reg) begin
                t1t_n = t_reg;
                t1i_n = cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            top_speed_reg <= TOP_SPEED_RST;
            cnt_reg       <= '0;
            ovt_reg       <= TIME_NONE;
            t0t_reg       <= TIME_NONE;
            t1t_reg       <= TIME_NONE;
            ovi_reg       <= '0;
            t0i_reg       <= '0;
            t1i_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr[2] == REG_TOP_SPEED) begin
                top_speed_reg <= pwdata;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
                cnt_reg     <= '0;
                ovt_reg     <= TIME_NONE;
                t0t_reg     <= TIME_NONE;
                t1t_reg     <= TIME_NONE;
                ovi_reg     <= '0;
                t0i_reg     <= '0;
                t1i_reg     <= '0;
            end else if (upd_go) begin
                ovt_reg <= ovt_n;
                ovi_reg <= ovi_n;
                t0t_reg <= t0t_n;
                t0i_reg <= t0i_n;
                t1t_reg <= t1t_n;
                t1i_reg <= t1i_n;
                if (cnt_reg < ROBOT_LIMIT) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_data;
        end
        if (state_reg == T_CALC && calc_done) begin
            t_reg <= calc_time;
        end
        if (emit) begin
            m_data_reg.best_robot  <= ovi_n;
            m_data_reg.win_time    <= ovt_n;
            m_data_reg.team0_robot <= t0i_n;
            m_data_reg.team0_time  <= t0t_n;
            m_data_reg.team1_robot <= t1i_n;
            m_data_reg.team1_time  <= t1t_n;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_TOP_SPEED) ? top_speed_reg : '0;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while a robot is in flight");

    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= ROBOT_LIMIT)
        else $error("robot index beyond limit");

    a_overall_min: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_data.win_time <= m_data.team0_time &&
                            m_data.win_time <= m_data.team1_time))
        else $error("overall time above a team time");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (cnt_reg == '0 && ovt_reg == TIME_NONE))
        else $error("frame not cleared after result");

endmodule
`default_nettype wire
